>>> src/mfdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfdb_pkg;

  // Field widths
  localparam int unsigned WordW = 32;
  localparam int unsigned RegW  = 6;
  localparam int unsigned ImmW  = 17;

  // Input tdata: instr_word, btb_hit, btb_taken, btb_target, redirect_pc
  localparam int unsigned InDataW  = 104;
  // Output tdata: instr_pc .. next_pc, 125 bits padded to bytes
  localparam int unsigned OutDataW = 128;
  localparam int unsigned OutUsedW = 125;

  // Configuration port
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgProgramStart = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgCodeEnd      = 1'd1;

  // Reset values
  localparam logic [WordW-1:0] ProgramStartRst = 32'd0;
  localparam logic [WordW-1:0] CodeEndRst      = 32'd4096;
  localparam logic [WordW-1:0] PcStep          = 32'd4;

  // "No register" / "no immediate" marks
  localparam logic [RegW-1:0] RegNone = {RegW{1'b1}};
  localparam logic [ImmW-1:0] ImmNone = {ImmW{1'b1}};

  typedef enum logic [2:0] {
    ClsMem     = 3'd0,
    ClsImm     = 3'd1,
    ClsBranch  = 3'd2,
    ClsJump    = 3'd3,
    ClsRegimm  = 3'd4,
    ClsSpecial = 3'd5
  } cls_e;

  typedef enum logic [4:0] {
    OpLw    = 5'd0,
    OpSw    = 5'd1,
    OpAddi  = 5'd2,
    OpAddiu = 5'd3,
    OpSlti  = 5'd4,
    OpBeq   = 5'd5,
    OpBne   = 5'd6,
    OpBlez  = 5'd7,
    OpBgtz  = 5'd8,
    OpJ     = 5'd9,
    OpBltz  = 5'd10,
    OpBgez  = 5'd11,
    OpSll   = 5'd12,
    OpSrl   = 5'd13,
    OpSra   = 5'd14,
    OpAdd   = 5'd15,
    OpAddu  = 5'd16,
    OpSub   = 5'd17,
    OpSubu  = 5'd18,
    OpAnd   = 5'd19,
    OpOr    = 5'd20,
    OpXor   = 5'd21,
    OpNor   = 5'd22,
    OpSlt   = 5'd23,
    OpSltu  = 5'd24,
    OpBreak = 5'd25,
    OpNop   = 5'd26
  } op_e;

  // Decoded fields of one instruction word
  typedef struct packed {
    cls_e            cls;
    op_e             op;
    logic [RegW-1:0] src;
    logic [RegW-1:0] tgt;
    logic [RegW-1:0] dst;
    logic [ImmW-1:0] off;
    logic [ImmW-1:0] imm;
    logic            ctrl;
  } dec_t;

endpackage

`default_nettype wire

>>> src/mfdb_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module mfdb_decode (
  input  wire logic [mfdb_pkg::WordW-1:0] word_i,
  output mfdb_pkg::dec_t                  dec_o
);
  import mfdb_pkg::*;

  logic [4:0] rs_f, rt_f, rd_f;
  op_e        special_op;

  assign rs_f = word_i[25:21];
  assign rt_f = word_i[20:16];
  assign rd_f = word_i[15:11];

  // Walk the function bits of a special word
  always_comb begin
    if (word_i[5]) begin
      if (word_i[3]) begin
        special_op = word_i[0] ? OpSltu : OpSlt;
      end else if (word_i[2]) begin
        if (word_i[1]) special_op = word_i[0] ? OpNor : OpXor;
        else           special_op = word_i[0] ? OpOr  : OpAnd;
      end else begin
        if (word_i[1]) special_op = word_i[0] ? OpSubu : OpSub;
        else           special_op = word_i[0] ? OpAddu : OpAdd;
      end
    end else if (word_i[3]) begin
      special_op = OpBreak;
    end else if (word_i[1]) begin
      special_op = word_i[0] ? OpSra : OpSrl;
    end else begin
      special_op = (word_i == '0) ? OpNop : OpSll;
    end
  end

  // Pick the class by priority of opcode bits, then fill the fields
  always_comb begin
    dec_o      = '0;
    dec_o.src  = RegNone;
    dec_o.tgt  = RegNone;
    dec_o.dst  = RegNone;
    dec_o.off  = ImmNone;
    dec_o.imm  = ImmNone;
    if (word_i[31]) begin
      dec_o.cls = ClsMem;
      dec_o.op  = word_i[29] ? OpSw : OpLw;
      dec_o.src = {1'b0, rs_f};
      dec_o.tgt = {1'b0, rt_f};
      dec_o.off = {1'b0, word_i[15:0]};
    end else if (word_i[29]) begin
      dec_o.cls = ClsImm;
      dec_o.op  = word_i[27] ? OpSlti : (word_i[26] ? OpAddiu : OpAddi);
      dec_o.src = {1'b0, rs_f};
      dec_o.tgt = {1'b0, rt_f};
      // ADDIU zero-extends, the others sign-extend
      if (!word_i[27] && word_i[26]) dec_o.imm = {1'b0, word_i[15:0]};
      else                           dec_o.imm = {word_i[15], word_i[15:0]};
    end else if (word_i[28]) begin
      dec_o.cls  = ClsBranch;
      dec_o.ctrl = 1'b1;
      if (word_i[27]) dec_o.op = word_i[26] ? OpBgtz : OpBlez;
      else            dec_o.op = word_i[26] ? OpBne  : OpBeq;
      dec_o.src = {1'b0, rs_f};
      if (!word_i[27]) dec_o.tgt = {1'b0, rt_f};
    end else if (word_i[27]) begin
      dec_o.cls  = ClsJump;
      dec_o.ctrl = 1'b1;
      dec_o.op   = OpJ;
    end else if (word_i[26]) begin
      dec_o.cls  = ClsRegimm;
      dec_o.ctrl = 1'b1;
      dec_o.op   = word_i[16] ? OpBgez : OpBltz;
      dec_o.src  = {1'b0, rs_f};
    end else begin
      dec_o.cls = ClsSpecial;
      dec_o.op  = special_op;
      if (special_op != OpBreak && special_op != OpNop) begin
        dec_o.src = {1'b0, rs_f};
        dec_o.tgt = {1'b0, rt_f};
        dec_o.dst = {1'b0, rd_f};
      end
    end
  end

endmodule

`default_nettype wire

>>> src/mips_fetch_decode_btb.sv
`timescale 1ns / 1ps
`default_nettype none

// Fetch and decode stage with branch target buffer prediction. For every
// accepted beat the word is decoded and the next PC predicted in the same
// cycle it is accepted, and the result lands in a single output register,
// so a new beat can be taken every clock while the result register drains.
// That rate is set by the fetch PC register, which is updated on each
// accepted beat. s_axis_tuser_i[0] set marks a redirect: it flushes, loads the
// PC from redirect_pc and clears the stop after a BREAK. While the PC is at or
// past the end of code (register 1), or after a BREAK, fetch beats return idle
// results carrying the unchanged PC. The fetch PC resets to the reset value of
// program_start; a write to program_start is taken but only matters at a
// reset, which also restores that register, so no storage is kept for it.
module mips_fetch_decode_btb (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [mfdb_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [mfdb_pkg::WordW-1:0]       cfg_data_i,
  // Input stream
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // instr_word[31:0], btb_hit[32], btb_taken[33], btb_target[65:34],
  // redirect_pc[97:66], zero pad
  input  wire logic [mfdb_pkg::InDataW-1:0]     s_axis_tdata_i,
  // kind[0]
  input  wire logic                             s_axis_tuser_i,
  // Output stream
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // instr_pc[31:0], instr_class[34:32], op_code[39:35], src_reg[45:40],
  // tgt_reg[51:46], dst_reg[57:52], mem_offset[74:58], imm_value[91:75],
  // predicted_taken[92], next_pc[124:93], zero pad
  output logic [mfdb_pkg::OutDataW-1:0]         m_axis_tdata_o,
  // valid_res[0], flush[1]
  output logic [1:0]                            m_axis_tuser_o
);
  import mfdb_pkg::*;

  logic [WordW-1:0]    code_end_q;
  logic [WordW-1:0]    pc_q, pc_d;
  logic                stop_q, stop_d;
  logic                out_vld_q;
  logic [OutUsedW-1:0] out_data_q, out_data_d;
  logic [1:0]          out_user_q, out_user_d;

  logic [WordW-1:0] instr_word, btb_target, redirect_pc, pc_inc;
  logic             btb_hit, btb_taken, pred, in_beat;
  dec_t             dec;

  assign instr_word  = s_axis_tdata_i[31:0];
  assign btb_hit     = s_axis_tdata_i[32];
  assign btb_taken   = s_axis_tdata_i[33];
  assign btb_target  = s_axis_tdata_i[65:34];
  assign redirect_pc = s_axis_tdata_i[97:66];

  // Accept while the result register is empty or draining
  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  mfdb_decode u_decode (
    .word_i (instr_word),
    .dec_o  (dec)
  );

  assign pred   = dec.ctrl && btb_hit && btb_taken;
  assign pc_inc = pc_q + PcStep;

  // Build the result and the next fetch state
  always_comb begin
    pc_d       = pc_q;
    stop_d     = stop_q;
    out_data_d = '0;
    out_user_d = '0;
    if (s_axis_tuser_i) begin
      pc_d                = redirect_pc;
      stop_d              = 1'b0;
      out_user_d          = 2'b10;
      out_data_d[124:93]  = redirect_pc;
    end else if (stop_q || pc_q >= code_end_q) begin
      out_data_d[124:93]  = pc_q;
    end else begin
      pc_d = pred ? btb_target : pc_inc;
      if (dec.op == OpBreak) stop_d = 1'b1;
      out_user_d          = 2'b01;
      out_data_d[31:0]    = pc_q;
      out_data_d[34:32]   = dec.cls;
      out_data_d[39:35]   = dec.op;
      out_data_d[45:40]   = dec.src;
      out_data_d[51:46]   = dec.tgt;
      out_data_d[57:52]   = dec.dst;
      out_data_d[74:58]   = dec.off;
      out_data_d[91:75]   = dec.imm;
      out_data_d[92]      = pred;
      out_data_d[124:93]  = pred ? btb_target : pc_inc;
    end
  end

  // Configuration: only the code end needs storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_end_q <= CodeEndRst;
    end else if (cfg_we_i && cfg_idx_i == CfgCodeEnd) begin
      code_end_q <= cfg_data_i;
    end
  end

  // Fetch state, advance on every accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= ProgramStartRst;
      stop_q <= 1'b0;
    end else if (in_beat) begin
      pc_q   <= pc_d;
      stop_q <= stop_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_vld_q <= s_axis_tvalid_i;
    end
  end

  // Result payload, hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW-OutUsedW){1'b0}}, out_data_q};
  assign m_axis_tuser_o  = out_user_q;

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mfdb_pkg::*;

  localparam int QuietLimit = 400;

  // One fetch or redirect beat as the sender sees it
  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] word;
    logic             hit;
    logic             taken;
    logic [WordW-1:0] target;
    logic [WordW-1:0] redirect;
  } fetch_item_t;

  // One decode result as it leaves the block
  typedef struct packed {
    logic             valid;
    logic             flush;
    logic [WordW-1:0] ipc;
    cls_e             cls;
    op_e              op;
    logic [RegW-1:0]  src;
    logic [RegW-1:0]  tgt;
    logic [RegW-1:0]  dst;
    logic [ImmW-1:0]  off;
    logic [ImmW-1:0]  imm;
    logic             pred;
    logic [WordW-1:0] npc;
  } fetch_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [WordW-1:0]    cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [1:0]          m_tuser;

  wire in_beat  = s_tvalid & s_tready;
  wire out_beat = m_tvalid & m_tready;

  // Stimulus and predicted results
  fetch_item_t   fetch_beats_q[$];
  fetch_result_t predicted_results_q[$];
  fetch_item_t   cur_item;

  // Shadow of the block state and its registers
  logic [WordW-1:0] pc_q = ProgramStartRst;
  logic             stopped_q = 1'b0;
  logic [WordW-1:0] code_end_q = CodeEndRst;

  int  n_queued = 0;
  int  n_taken = 0;
  int  n_decoded = 0;
  int  n_redirect = 0;
  int  n_idle = 0;
  int  n_pred_taken = 0;
  int  n_checked = 0;
  int  fail_count = 0;
  int  idle_odds = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  bit  op_seen [27];

  mips_fetch_decode_btb dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Pick an operation for the function field of a special-group word
  function automatic op_e special_kind(logic [WordW-1:0] w);
    if (w[5]) begin
      if (w[3]) return w[0] ? OpSltu : OpSlt;
      if (w[2]) begin
        if (w[1]) return w[0] ? OpNor : OpXor;
        return w[0] ? OpOr : OpAnd;
      end
      if (w[1]) return w[0] ? OpSubu : OpSub;
      return w[0] ? OpAddu : OpAdd;
    end
    if (w[3]) return OpBreak;
    if (w[1]) return w[0] ? OpSra : OpSrl;
    return (w == '0) ? OpNop : OpSll;
  endfunction

  // Decode one accepted beat, advance the shadow PC and queue the result
  task automatic decode_and_advance(input fetch_item_t it);
    fetch_result_t r;
    logic [WordW-1:0] w;
    r = '0;
    w = it.word;
    if (it.kind) begin
      pc_q = it.redirect;
      stopped_q = 1'b0;
      r.flush = 1'b1;
      r.npc = pc_q;
      n_redirect++;
    end else if (stopped_q || pc_q >= code_end_q) begin
      r.npc = pc_q;
      n_idle++;
    end else begin
      r.valid = 1'b1;
      r.ipc = pc_q;
      r.src = RegNone;
      r.tgt = RegNone;
      r.dst = RegNone;
      r.off = ImmNone;
      r.imm = ImmNone;
      if (w[31]) begin
        r.cls = ClsMem;
        r.op = w[29] ? OpSw : OpLw;
        r.src = {1'b0, w[25:21]};
        r.tgt = {1'b0, w[20:16]};
        r.off = {1'b0, w[15:0]};
      end else if (w[29]) begin
        r.cls = ClsImm;
        r.op = w[27] ? OpSlti : (w[26] ? OpAddiu : OpAddi);
        r.src = {1'b0, w[25:21]};
        r.tgt = {1'b0, w[20:16]};
        r.imm = (r.op == OpAddiu) ? {1'b0, w[15:0]} : {w[15], w[15:0]};
      end else if (w[28]) begin
        r.cls = ClsBranch;
        if (w[27]) r.op = w[26] ? OpBgtz : OpBlez;
        else r.op = w[26] ? OpBne : OpBeq;
        r.src = {1'b0, w[25:21]};
        if (!w[27]) r.tgt = {1'b0, w[20:16]};
      end else if (w[27]) begin
        r.cls = ClsJump;
        r.op = OpJ;
      end else if (w[26]) begin
        r.cls = ClsRegimm;
        r.op = w[16] ? OpBgez : OpBltz;
        r.src = {1'b0, w[25:21]};
      end else begin
        r.cls = ClsSpecial;
        r.op = special_kind(w);
        if (r.op != OpBreak && r.op != OpNop) begin
          r.src = {1'b0, w[25:21]};
          r.tgt = {1'b0, w[20:16]};
          r.dst = {1'b0, w[15:11]};
        end
      end
      // Follow the BTB only for control ops
      if (r.cls == ClsBranch || r.cls == ClsJump || r.cls == ClsRegimm)
        r.pred = it.hit & it.taken;
      pc_q = r.pred ? it.target : pc_q + PcStep;
      if (r.op == OpBreak) stopped_q = 1'b1;
      r.npc = pc_q;
      n_decoded++;
      if (r.pred) n_pred_taken++;
      op_seen[int'(r.op)] = 1'b1;
    end
    predicted_results_q.push_back(r);
  endtask

  // Build a word that decodes to the given op, other bits random (NOP is all zeros)
  function automatic logic [WordW-1:0] make_word(op_e op);
    logic [WordW-1:0] w;
    w = $urandom;
    w[31] = (op == OpLw || op == OpSw);
    case (op)
      OpLw:    w[29] = 1'b0;
      OpSw:    w[29] = 1'b1;
      OpAddi:  {w[29], w[27:26]} = 3'b100;
      OpAddiu: {w[29], w[27:26]} = 3'b101;
      OpSlti:  {w[29], w[27]} = 2'b11;
      OpBeq:   w[29:26] = 4'b0100;
      OpBne:   w[29:26] = 4'b0101;
      OpBlez:  w[29:26] = 4'b0110;
      OpBgtz:  w[29:26] = 4'b0111;
      OpJ:     w[29:27] = 3'b001;
      OpBltz: begin
        w[29:26] = 4'b0001;
        w[16] = 1'b0;
      end
      OpBgez: begin
        w[29:26] = 4'b0001;
        w[16] = 1'b1;
      end
      default: begin
        w[29:26] = 4'b0000;
        case (op)
          OpSll:   {w[5], w[3], w[1]} = 3'b000;
          OpSrl:   {w[5], w[3], w[1:0]} = 4'b0010;
          OpSra:   {w[5], w[3], w[1:0]} = 4'b0011;
          OpAdd:   {w[5], w[3:0]} = 5'b10000;
          OpAddu:  {w[5], w[3:0]} = 5'b10001;
          OpSub:   {w[5], w[3:0]} = 5'b10010;
          OpSubu:  {w[5], w[3:0]} = 5'b10011;
          OpAnd:   {w[5], w[3:0]} = 5'b10100;
          OpOr:    {w[5], w[3:0]} = 5'b10101;
          OpXor:   {w[5], w[3:0]} = 5'b10110;
          OpNor:   {w[5], w[3:0]} = 5'b10111;
          OpSlt:   {w[5], w[3], w[0]} = 3'b110;
          OpSltu:  {w[5], w[3], w[0]} = 3'b111;
          OpBreak: {w[5], w[3]} = 2'b01;
          default: w = '0;
        endcase
        // keep a shift from collapsing into the all-zero NOP
        if (op == OpSll && w == '0) w[6] = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Address inside the code region, near its end, or anywhere at all
  function automatic logic [WordW-1:0] code_addr();
    logic [WordW-1:0] a;
    if (code_end_q < 8 || $urandom_range(0, 9) == 0) return $urandom;
    if ($urandom_range(0, 3) == 0) a = code_end_q - $urandom_range(1, 32);
    else a = $urandom_range(0, code_end_q - 1);
    return {a[31:2], 2'b00};
  endfunction

  task automatic push_fetch(logic [WordW-1:0] word, logic hit, logic taken,
                            logic [WordW-1:0] target);
    fetch_item_t it;
    it = '{kind: 1'b0, word: word, hit: hit, taken: taken, target: target,
           redirect: $urandom};
    fetch_beats_q.push_back(it);
    n_queued++;
  endtask

  task automatic push_redirect(logic [WordW-1:0] pc);
    fetch_item_t it;
    it = '{kind: 1'b1, word: $urandom, hit: 1'($urandom_range(0, 1)),
           taken: 1'($urandom_range(0, 1)), target: $urandom, redirect: pc};
    fetch_beats_q.push_back(it);
    n_queued++;
  endtask

  // Redirects at the given percentage, else mostly decodable words, some raw noise, BREAK kept rare
  task automatic push_random(int redirect_pct);
    op_e op;
    logic [WordW-1:0] word;
    if ($urandom_range(0, 99) < redirect_pct) begin
      push_redirect(code_addr());
    end else begin
      if ($urandom_range(0, 6) == 0) begin
        word = $urandom;
      end else begin
        op = op_e'($urandom_range(0, int'(OpNop)));
        if (op == OpBreak && $urandom_range(0, 2) != 0) op = OpOr;
        word = make_word(op);
      end
      push_fetch(word, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                 code_addr());
    end
  endtask

  // Feed random beats until enough decodes and redirects have gone in
  task automatic run_phase(int goal, int redirect_pct);
    int start;
    start = n_decoded + n_redirect;
    while (n_decoded + n_redirect - start < goal) begin
      if (fetch_beats_q.size() < 4) push_random(redirect_pct);
      @(posedge clk);
    end
  endtask

  // Hold off until every beat is in and every result is out
  task automatic drain();
    while (n_taken != n_queued || predicted_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    // program_start only matters at a reset, so the shadow PC stays put
    if (idx == CfgCodeEnd) code_end_q = value;
  endtask

  function automatic bit field_ok(string name, logic [WordW-1:0] want,
                                  logic [WordW-1:0] got);
    if (want === got) return 1'b1;
    if (fail_count < 10)
      $display("[%0t] result %0d %s mismatch: expected %h got %h",
               $time, n_checked, name, want, got);
    return 1'b0;
  endfunction

  task automatic check_result();
    fetch_result_t want;
    fetch_result_t got;
    bit ok;
    got.valid = m_tuser[0];
    got.flush = m_tuser[1];
    got.ipc   = m_tdata[31:0];
    got.cls   = cls_e'(m_tdata[34:32]);
    got.op    = op_e'(m_tdata[39:35]);
    got.src   = m_tdata[45:40];
    got.tgt   = m_tdata[51:46];
    got.dst   = m_tdata[57:52];
    got.off   = m_tdata[74:58];
    got.imm   = m_tdata[91:75];
    got.pred  = m_tdata[92];
    got.npc   = m_tdata[124:93];
    if (predicted_results_q.size() == 0) begin
      if (fail_count < 10)
        $display("[%0t] result beat with nothing pending: tdata %h tuser %b",
                 $time, m_tdata, m_tuser);
      fail_count++;
    end else begin
      want = predicted_results_q.pop_front();
      ok = 1'b1;
      ok &= field_ok("valid_res", 32'(want.valid), 32'(got.valid));
      ok &= field_ok("flush", 32'(want.flush), 32'(got.flush));
      ok &= field_ok("instr_pc", want.ipc, got.ipc);
      ok &= field_ok("instr_class", 32'(want.cls), 32'(got.cls));
      ok &= field_ok("op_code", 32'(want.op), 32'(got.op));
      ok &= field_ok("src_reg", 32'(want.src), 32'(got.src));
      ok &= field_ok("tgt_reg", 32'(want.tgt), 32'(got.tgt));
      ok &= field_ok("dst_reg", 32'(want.dst), 32'(got.dst));
      ok &= field_ok("mem_offset", 32'(want.off), 32'(got.off));
      ok &= field_ok("imm_value", 32'(want.imm), 32'(got.imm));
      ok &= field_ok("predicted_taken", 32'(want.pred), 32'(got.pred));
      ok &= field_ok("next_pc", want.npc, got.npc);
      if (!ok) fail_count++;
    end
    n_checked++;
  endtask

  // Driver: predict on each accepted beat, then offer the next one or idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_beat) begin
        decode_and_advance(cur_item);
        n_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          send_gap = $urandom_range(0, 10);
          s_tvalid <= 1'b0;
        end else if (fetch_beats_q.size() != 0) begin
          cur_item = fetch_beats_q.pop_front();
          s_tdata <= {6'b0, cur_item.redirect, cur_item.target, cur_item.taken,
                      cur_item.hit, cur_item.word};
          s_tuser <= cur_item.kind;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat and stall the output in bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_beat) check_result();
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left = $urandom_range(0, 10);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_beat || out_beat) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    op_e op;
    int ops_hit;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(CfgProgramStart, 32'hFFFF_FFFC);
    write_reg(CfgCodeEnd, CodeEndRst);

    // Every op once from PC 0; BREAK stops fetch, so the NOP after it idles
    for (int k = int'(OpLw); k <= int'(OpNop); k++) begin
      op = op_e'(k);
      push_fetch(make_word(op), op != OpBlez, op != OpBne, 32'h0000_0100 + 32'(k * 8));
    end
    push_redirect(32'h0000_0010);
    push_fetch(32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0);
    push_fetch(32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // Run off the end of code
    push_redirect(CodeEndRst - 8);
    repeat (3) push_fetch(make_word(OpAdd), 1'b1, 1'b1, 32'h0);

    idle_odds = 6;
    run_phase(350, 5);
    drain();

    // Tiny code region
    write_reg(CfgCodeEnd, 32'h0000_0040);
    write_reg(CfgProgramStart, {30'($urandom_range(0, 32'h3FFF_FFFF)), 2'b00});
    push_redirect(32'h0);
    run_phase(250, 12);
    drain();

    // No code at all: every fetch idles
    write_reg(CfgCodeEnd, 32'h0);
    run_phase(20, 20);
    drain();

    // Code ends at the top address, so all but 0xFFFFFFFF is code; wrap the PC past the top
    write_reg(CfgProgramStart, 32'h0);
    write_reg(CfgCodeEnd, 32'hFFFF_FFFF);
    push_redirect(32'hFFFF_FFF4);
    repeat (4) push_fetch(make_word(OpAddu), 1'b0, 1'b0, 32'h0);
    push_redirect(32'hFFFF_FFFF);
    push_fetch(make_word(OpLw), 1'b1, 1'b1, 32'h0);
    push_redirect(32'h0);
    run_phase(250, 5);
    idle_odds = 0;
    run_phase(100, 5);
    drain();

    write_reg(CfgCodeEnd, {30'($urandom_range(32'h40, 32'h1000)), 2'b00});
    push_redirect(32'h0);
    idle_odds = 6;
    run_phase(200, 6);
    // Full rate to the end
    idle_odds = 0;
    run_phase(200, 5);
    drain();
    repeat (8) @(posedge clk);

    ops_hit = 0;
    foreach (op_seen[i]) ops_hit += op_seen[i];
    $display("Ran %0d beats: %0d decoded covering %0d of 27 ops, %0d predicted taken,",
             n_taken, n_decoded, ops_hit, n_pred_taken);
    $display("%0d redirects and %0d idle fetches with the code end from 0 to all ones.",
             n_redirect, n_idle);
    if (fail_count == 0 && predicted_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/mfdb_pkg.sv
src/mfdb_decode.sv
src/mips_fetch_decode_btb.sv
bench/testbench.sv
